// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant
`define WDED_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// same-cycle implication
`define WDED_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define WDED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/wded_pkg.sv =====
// ----------------------------------------------------------------------------
// wded_pkg
// types, constants and helpers for the weighted edit distance block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wded_pkg;

  localparam int MAX_LEN  = 256;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DIST_W   = 13;
  localparam int COST_W   = 4;
  localparam int SYM_W    = 3;
  localparam int FUNC_W   = 2;
  localparam int ERR_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // symbol codes
  localparam logic [SYM_W-1:0] SYM_A   = 3'd0;
  localparam logic [SYM_W-1:0] SYM_GAP = 3'd4;
  // a-g and c-t differ in bit 1 only
  localparam logic [SYM_W-1:0] TRANSITION_XOR = 3'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SYMBOL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSVERSION = 2'd2;

  localparam logic [COST_W-1:0] GAP_RESET          = 4'd3;
  localparam logic [COST_W-1:0] TRANSITION_RESET   = 4'd2;
  localparam logic [COST_W-1:0] TRANSVERSION_RESET = 4'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ERR_W-1:0]  error;
  } out_item_t;

  typedef struct packed {
    logic [COST_W-1:0] gap;
    logic [COST_W-1:0] transition;
    logic [COST_W-1:0] transversion;
  } cost_cfg_t;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [IDX_W-1:0]  addr;
    logic [SYM_W-1:0]  sym;
  } load_req_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] m;
    logic [LEN_W-1:0] n;
  } eng_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_ROWGO,
    ST_RD,
    ST_CELL,
    ST_DONE
  } eng_state_t;

  // add a cost to a distance, clamped at the top of the range
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {{(DIST_W + 1 - COST_W){1'b0}}, b};
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/wded_cell_unit.sv =====
// ----------------------------------------------------------------------------
// wded_cell_unit
// one table cell: substitution cost, three adds and a three-way minimum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wded_cell_unit (
  input  logic [wded_pkg::DIST_W-1:0] diag,
  input  logic [wded_pkg::DIST_W-1:0] left,
  input  logic [wded_pkg::DIST_W-1:0] up,
  input  logic [wded_pkg::SYM_W-1:0]  sym_a,
  input  logic [wded_pkg::SYM_W-1:0]  sym_b,
  input  wded_pkg::cost_cfg_t         costs,
  output logic [wded_pkg::DIST_W-1:0] cell_val
);
  import wded_pkg::*;

  logic [COST_W-1:0] sub;
  logic [DIST_W-1:0] d_sum, l_sum, u_sum, m1;

  always_comb begin
    if (sym_a == sym_b) begin
      sub = '0;
    end else if (sym_a == SYM_GAP || sym_b == SYM_GAP) begin
      sub = costs.gap;
    end else if ((sym_a ^ sym_b) == TRANSITION_XOR) begin
      sub = costs.transition;
    end else begin
      sub = costs.transversion;
    end
  end

  always_comb begin
    d_sum    = sat_add(diag, sub);
    l_sum    = sat_add(left, costs.gap);
    u_sum    = sat_add(up, costs.gap);
    m1       = (l_sum < d_sum) ? l_sum : d_sum;
    cell_val = (u_sum < m1) ? u_sum : m1;
  end

endmodule

`default_nettype wire

// ===== rtl/wded_engine.sv =====
// ----------------------------------------------------------------------------
// wded_engine
// sequence stores, working row and the sequencer that walks the table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wded_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wded_pkg::eng_ctl_t          ctl,
  input  wded_pkg::load_req_t         ld,
  input  wded_pkg::cost_cfg_t         costs,
  output logic                        busy,
  output logic                        done,
  output logic [wded_pkg::DIST_W-1:0] dist_val
);
  import wded_pkg::*;

  eng_state_t state_r, state_nxt;

  logic [LEN_W-1:0]  x_r, x_nxt, y_r, y_nxt, m_r, m_nxt, n_r, n_nxt;
  logic [DIST_W-1:0] acc_r, acc_nxt, base_r, base_nxt;
  logic [DIST_W-1:0] diag_r, diag_nxt, left_r, left_nxt, last_r, last_nxt;
  logic [DIST_W-1:0] new_base, cell_val;
  logic [LEN_W-1:0]  x_dec, y_dec;

  logic [SYM_W-1:0]  first_mem  [0:MAX_LEN-1];
  logic [SYM_W-1:0]  second_mem [0:MAX_LEN-1];
  logic [DIST_W-1:0] row_mem    [0:MAX_LEN];
  logic [SYM_W-1:0]  first_q, second_q;
  logic [DIST_W-1:0] row_q;

  logic              row_we;
  logic [DIST_W-1:0] row_wdata;

  assign x_dec    = x_r - 1'b1;
  assign y_dec    = y_r - 1'b1;
  assign new_base = sat_add(base_r, costs.gap);
  assign busy     = (state_r != ST_IDLE);
  assign dist_val = last_r;

  wded_cell_unit u_cell (
    .diag     (diag_r),
    .left     (left_r),
    .up       (row_q),
    .sym_a    (first_q),
    .sym_b    (second_q),
    .costs    (costs),
    .cell_val (cell_val)
  );

  // memories
  always_ff @(posedge clk) begin
    if (ld.we_a) begin
      first_mem[ld.addr] <= ld.sym;
    end
    if (ld.we_b) begin
      second_mem[ld.addr] <= ld.sym;
    end
    if (state_r == ST_ROW) begin
      first_q <= first_mem[x_dec[IDX_W-1:0]];
    end
    if (state_r == ST_RD) begin
      second_q <= second_mem[y_dec[IDX_W-1:0]];
      row_q    <= row_mem[y_r];
    end
    if (row_we) begin
      row_mem[y_r] <= row_wdata;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl.start) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        if (y_r == n_r) state_nxt = (m_r == '0) ? ST_DONE : ST_ROW;
      end
      ST_ROW: state_nxt = ST_ROWGO;
      ST_ROWGO: begin
        if (n_r == '0) state_nxt = (x_r == m_r) ? ST_DONE : ST_ROW;
        else           state_nxt = ST_RD;
      end
      ST_RD: state_nxt = ST_CELL;
      ST_CELL: begin
        if (y_r == n_r) state_nxt = (x_r == m_r) ? ST_DONE : ST_ROW;
        else            state_nxt = ST_RD;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    diag_nxt  = diag_r;
    left_nxt  = left_r;
    last_nxt  = last_r;
    row_we    = 1'b0;
    row_wdata = acc_r;
    done      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          m_nxt    = ctl.m;
          n_nxt    = ctl.n;
          x_nxt    = LEN_W'(1);
          y_nxt    = '0;
          acc_nxt  = '0;
          base_nxt = '0;
        end
      end
      ST_INIT: begin
        row_we   = 1'b1;
        last_nxt = acc_r;
        acc_nxt  = sat_add(acc_r, costs.gap);
        if (y_r != n_r) y_nxt = y_r + 1'b1;
      end
      ST_ROWGO: begin
        diag_nxt = base_r;
        base_nxt = new_base;
        left_nxt = new_base;
        last_nxt = new_base;
        y_nxt    = LEN_W'(1);
        if (n_r == '0 && x_r != m_r) x_nxt = x_r + 1'b1;
      end
      ST_CELL: begin
        row_we    = 1'b1;
        row_wdata = cell_val;
        left_nxt  = cell_val;
        diag_nxt  = row_q;
        last_nxt  = cell_val;
        if (y_r == n_r) begin
          if (x_r != m_r) x_nxt = x_r + 1'b1;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    m_r    <= m_nxt;
    n_r    <= n_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    diag_r <= diag_nxt;
    left_r <= left_nxt;
    last_r <= last_nxt;
  end

`include "assert_macros.svh"

  `WDED_ASSERT_IMPLY(a_col_range, state_r == ST_RD || state_r == ST_CELL, y_r != '0 && y_r <= n_r)
  `WDED_ASSERT_IMPLY(a_row_range, state_r == ST_ROW || state_r == ST_ROWGO || state_r == ST_RD || state_r == ST_CELL, x_r != '0 && x_r <= m_r)
  `WDED_ASSERT_NEXT(a_init_exit, state_r == ST_INIT && y_r == n_r, state_r == ST_ROW || state_r == ST_DONE)

endmodule

`default_nettype wire

// ===== rtl/weighted_dna_edit_distance_top.sv =====
// ----------------------------------------------------------------------------
// weighted_dna_edit_distance_top
// weighted edit distance between two loaded nucleotide sequences
// ----------------------------------------------------------------------------
// usage
//   request channel: start with in_data, taken at an edge where start is high
//   and busy is low. func load a / load b appends one symbol; the next request
//   may follow at once. func compute walks the table and returns one result
//   on out_valid/out_data for exactly one cycle; the receiver cannot stall it.
//   with m = first length and n = second length, busy stays high while the
//   sequencer writes the n + 1 initial row entries and then walks the m * n
//   table cells through the single shared cell unit (row memory read, then
//   compute and write back). the result shows in the first cycle with busy low.
//   if an error was flagged, compute gives distance 0 and the code on the
//   cycle after the request, with busy staying low.
//   compute clears both lengths and the error flag.
//   cfg port: cfg_valid with cfg_index and cfg_data, always ready; write only
//   while no compute is in flight.
//   reset (synchronous, active low): costs back to 3 / 2 / 4, lengths and
//   error cleared, sequencer idle; store contents stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module weighted_dna_edit_distance_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  wded_pkg::in_item_t             in_data,
  output logic                           out_valid,
  output wded_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wded_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wded_pkg::COST_W-1:0]    cfg_data
);
  import wded_pkg::*;

  // configuration costs
  cost_cfg_t cost_r, cost_nxt;

  // sequence lengths and sticky error
  logic [LEN_W-1:0] len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic             accept, sel_b;
  logic [LEN_W-1:0] cur_len;
  load_req_t        ld;
  eng_ctl_t         eng_ctl;
  logic             eng_busy, eng_done;
  logic [DIST_W-1:0] eng_dist;

  assign accept    = start & ~busy;
  assign busy      = eng_busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign sel_b     = (in_data.func == FUNC_LOAD_B);
  assign cur_len   = sel_b ? len_b_r : len_a_r;

  wded_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (eng_ctl),
    .ld       (ld),
    .costs    (cost_r),
    .busy     (eng_busy),
    .done     (eng_done),
    .dist_val (eng_dist)
  );

  // config writes
  always_comb begin
    cost_nxt = cost_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAP:          cost_nxt.gap          = cfg_data;
        REG_TRANSITION:   cost_nxt.transition   = cfg_data;
        REG_TRANSVERSION: cost_nxt.transversion = cfg_data;
        default: ;
      endcase
    end
  end

  // request decode
  always_comb begin
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    err_nxt       = err_r;
    ld            = '0;
    eng_ctl       = '0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (accept) begin
      case (in_data.func)
        FUNC_LOAD_A, FUNC_LOAD_B: begin
          if (!(in_data.symbol inside {[SYM_A:SYM_GAP]})) begin
            // bad symbol dropped, first error kept
            if (err_r == ERR_NONE) err_nxt = ERR_SYMBOL;
          end else if (cur_len >= MAX_LEN_L) begin
            // store full, symbol dropped
            if (err_r == ERR_NONE) err_nxt = ERR_OVERFLOW;
          end else begin
            ld.we_a = ~sel_b;
            ld.we_b = sel_b;
            ld.addr = cur_len[IDX_W-1:0];
            ld.sym  = in_data.symbol;
            if (sel_b) len_b_nxt = len_b_r + 1'b1;
            else       len_a_nxt = len_a_r + 1'b1;
          end
        end
        FUNC_COMPUTE: begin
          len_a_nxt = '0;
          len_b_nxt = '0;
          err_nxt   = ERR_NONE;
          if (err_r != ERR_NONE) begin
            // error pending: answer at once, no table walk
            out_valid_nxt         = 1'b1;
            out_data_nxt.distance = '0;
            out_data_nxt.error    = err_r;
          end else begin
            eng_ctl.start = 1'b1;
            eng_ctl.m     = len_a_r;
            eng_ctl.n     = len_b_r;
          end
        end
        default: ;
      endcase
    end
    if (eng_done) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.distance = eng_dist;
      out_data_nxt.error    = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r      <= '{gap: GAP_RESET, transition: TRANSITION_RESET,
                       transversion: TRANSVERSION_RESET};
      len_a_r     <= '0;
      len_b_r     <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      cost_r      <= cost_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

`include "assert_macros.svh"

  // a clean compute must hold the request side off
  `WDED_ASSERT_NEXT(a_launch_busy, accept && in_data.func == FUNC_COMPUTE && err_r == ERR_NONE, busy)
  // results never come back to back
  `WDED_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r)
  `WDED_ASSERT(a_len_bound, len_a_r <= MAX_LEN_L && len_b_r <= MAX_LEN_L)

endmodule

`default_nettype wire

// ===== test/wded_checker.sv =====
// ----------------------------------------------------------------------------
// wded_checker
// watches the request, result and register channels of the weighted edit
// distance block, keeps its own copy of both sequences and the costs, works
// out each distance and compares it field by field with what the block sends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wded_checker
  import wded_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   results_owed
);

  localparam int unsigned DIST_LIMIT = (1 << DIST_W) - 1;

  logic [SYM_W-1:0]  first_seq  [MAX_LEN];
  logic [SYM_W-1:0]  second_seq [MAX_LEN];
  int unsigned       first_len;
  int unsigned       second_len;
  logic [ERR_W-1:0]  held_err;
  logic [COST_W-1:0] gap_w;
  logic [COST_W-1:0] transition_w;
  logic [COST_W-1:0] transversion_w;
  out_item_t         distance_q [$];

  function automatic int unsigned pair_cost(input logic [SYM_W-1:0] p,
                                            input logic [SYM_W-1:0] q);
    if (p == q) return 0;
    if (p == SYM_GAP || q == SYM_GAP) return gap_w;
    if ((p ^ q) == TRANSITION_XOR) return transition_w;
    return transversion_w;
  endfunction

  // one working row, filled row by row over the first sequence
  function automatic int unsigned alignment_cost();
    int unsigned row [MAX_LEN+1];
    int unsigned diag;
    int unsigned up;
    int unsigned best;
    for (int y = 0; y <= second_len; y++) row[y] = y * gap_w;
    for (int x = 1; x <= first_len; x++) begin
      diag   = row[0];
      row[0] = x * gap_w;
      for (int y = 1; y <= second_len; y++) begin
        up   = row[y];
        best = diag + pair_cost(first_seq[x-1], second_seq[y-1]);
        if (row[y-1] + gap_w < best) best = row[y-1] + gap_w;
        if (up + gap_w < best) best = up + gap_w;
        diag   = up;
        row[y] = best;
      end
    end
    return row[second_len];
  endfunction

  task automatic store_symbol(input bit to_second, input logic [SYM_W-1:0] s);
    int unsigned fill;
    fill = to_second ? second_len : first_len;
    if (s > SYM_GAP) begin
      if (held_err == ERR_NONE) held_err = ERR_SYMBOL;
    end else if (fill >= MAX_LEN) begin
      if (held_err == ERR_NONE) held_err = ERR_OVERFLOW;
    end else if (to_second) begin
      second_seq[fill] = s;
      second_len++;
    end else begin
      first_seq[fill] = s;
      first_len++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t   want;
    int unsigned cost_sum;
    if (!rst_n) begin
      first_len      = 0;
      second_len     = 0;
      held_err       = ERR_NONE;
      gap_w          = GAP_RESET;
      transition_w   = TRANSITION_RESET;
      transversion_w = TRANSVERSION_RESET;
      distance_q.delete();
    end else begin
      if (out_valid) begin
        if (distance_q.size() == 0) begin
          $error("result with nothing owed: distance %0d error %0d",
                 out_data.distance, out_data.error);
          mismatch_count++;
        end else begin
          want = distance_q.pop_front();
          if (out_data.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_data.distance);
            mismatch_count++;
          end
          if (out_data.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_data.error);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAP:          gap_w = cfg_data;
          REG_TRANSITION:   transition_w = cfg_data;
          REG_TRANSVERSION: transversion_w = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_data.func)
          FUNC_LOAD_A: store_symbol(1'b0, in_data.symbol);
          FUNC_LOAD_B: store_symbol(1'b1, in_data.symbol);
          FUNC_COMPUTE: begin
            cost_sum = 0;
            if (held_err == ERR_NONE) begin
              cost_sum = alignment_cost();
              if (cost_sum > DIST_LIMIT) cost_sum = DIST_LIMIT;
            end
            want.distance = DIST_W'(cost_sum);
            want.error    = held_err;
            distance_q.push_back(want);
            first_len  = 0;
            second_len = 0;
            held_err   = ERR_NONE;
          end
          default: ;
        endcase
      end
    end
    results_owed = distance_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives load and compute requests and cost register writes into the
// weighted edit distance block, with a checker beside it; a short directed
// run is followed by randomised jobs under changing costs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wded_pkg::*;

  // codes the package leaves unnamed
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [SYM_W-1:0]     SYM_C       = 3'd1;
  localparam logic [SYM_W-1:0]     SYM_G       = 3'd2;
  localparam logic [SYM_W-1:0]     SYM_T       = 3'd3;
  localparam logic [SYM_W-1:0]     SYM_TOP     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [COST_W-1:0]    COST_MIN    = 4'd0;
  localparam logic [COST_W-1:0]    COST_MAX    = 4'd15;

  localparam int ITEM_TARGET  = 1550;
  localparam int DRAIN_CYCLES = 8;
  localparam int END_CYCLES   = 20;
  // longest quiet stretch of a correct run: a full-size table walk
  localparam int SLOWEST_JOB  = (MAX_LEN + 1) + MAX_LEN * (2 + 2 * MAX_LEN) + 2;
  localparam int STALL_LIMIT  = 4 * SLOWEST_JOB + 1000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COST_W-1:0]    cfg_data  = '0;

  int mismatch_count;
  int results_owed;
  int items_sent;
  int idle_cycles;
  int phase;
  int noise_pct;
  bit gaps_on;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  weighted_dna_edit_distance_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wded_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // mostly back to back, some short breathers, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // short sequences dominate so the table walks stay cheap
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 32);
    return $urandom_range(33, 64);
  endfunction

  // start drops only here and in settle, never in the step where a request is raised
  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // hold the request until the block takes it (start high, busy low)
  task automatic push_request(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
    in_item_t req;
    req.func   = f;
    req.symbol = s;
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (f != FUNC_UNUSED) items_sent++;
    pause(gap_len());
  endtask

  // sender holds off until every owed distance is back and loads have landed
  task automatic settle();
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes never toggle it in one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COST_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [COST_W-1:0] g, input logic [COST_W-1:0] t,
                             input logic [COST_W-1:0] v, input bit poke_unused);
    settle();
    if (poke_unused) write_reg(REG_UNUSED, COST_W'($urandom_range(0, 15)));
    write_reg(REG_GAP, g);
    write_reg(REG_TRANSITION, t);
    write_reg(REG_TRANSVERSION, v);
    cfg_valid <= 1'b0;
  endtask

  // load both sequences in a random interleave, then ask for the distance;
  // noise_pct sprinkles bad symbols and unused-function requests
  task automatic run_job(input int m, input int n, input int noise);
    int               a;
    int               b;
    bit               to_second;
    logic [SYM_W-1:0] s;
    a = m;
    b = n;
    while (a + b > 0) begin
      to_second = (a == 0) || (b != 0 && $urandom_range(0, 1) == 1);
      if ($urandom_range(0, 99) < noise) s = SYM_W'($urandom_range(SYM_GAP + 1, SYM_TOP));
      else s = SYM_W'($urandom_range(SYM_A, SYM_GAP));
      push_request(to_second ? FUNC_LOAD_B : FUNC_LOAD_A, s);
      if (to_second) b--;
      else a--;
      if ($urandom_range(0, 99) < noise) begin
        push_request(FUNC_UNUSED, SYM_W'($urandom_range(SYM_A, SYM_TOP)));
      end
    end
    push_request(FUNC_COMPUTE, SYM_W'($urandom_range(SYM_A, SYM_TOP)));
  endtask

  initial begin
    // synchronous reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset costs, no gaps ----
    // both sequences empty
    push_request(FUNC_COMPUTE, SYM_A);
    // every symbol, pairs giving transition, transversion and gap-gap match
    push_request(FUNC_LOAD_A, SYM_A);
    push_request(FUNC_LOAD_A, SYM_C);
    push_request(FUNC_LOAD_A, SYM_G);
    push_request(FUNC_LOAD_A, SYM_T);
    push_request(FUNC_LOAD_A, SYM_GAP);
    push_request(FUNC_LOAD_B, SYM_G);
    push_request(FUNC_LOAD_B, SYM_T);
    push_request(FUNC_LOAD_B, SYM_C);
    push_request(FUNC_LOAD_B, SYM_A);
    push_request(FUNC_LOAD_B, SYM_GAP);
    // unused function code must leave the sequences alone
    push_request(FUNC_UNUSED, SYM_TOP);
    push_request(FUNC_COMPUTE, SYM_TOP);
    // bad symbols on both sides, then a good one: error flagged, distance zero
    push_request(FUNC_LOAD_A, SYM_TOP);
    push_request(FUNC_LOAD_B, SYM_W'(SYM_GAP + 1));
    push_request(FUNC_LOAD_A, SYM_C);
    push_request(FUNC_COMPUTE, SYM_A);
    // error cleared by the compute; second sequence empty
    push_request(FUNC_LOAD_A, SYM_G);
    push_request(FUNC_COMPUTE, SYM_A);
    // first sequence empty
    push_request(FUNC_LOAD_B, SYM_T);
    push_request(FUNC_LOAD_B, SYM_T);
    push_request(FUNC_COMPUTE, SYM_A);

    // ---- random part ----
    items_sent = 0;
    phase      = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      case (phase)
        1: reconfigure(COST_MAX, COST_MAX, COST_MAX, 1'b1);
        2: reconfigure(COST_MIN, COST_MIN, COST_MIN, 1'b0);
        default: begin
          case ($urandom_range(0, 5))
            0: reconfigure(GAP_RESET, TRANSITION_RESET, TRANSVERSION_RESET, 1'b0);
            1: reconfigure(COST_MAX, COST_MIN, COST_MAX, 1'b0);
            default: reconfigure(COST_W'($urandom_range(0, 15)), COST_W'($urandom_range(0, 15)),
                                 COST_W'($urandom_range(0, 15)), 1'b0);
          endcase
        end
      endcase
      gaps_on   = ($urandom_range(0, 3) != 0);
      noise_pct = $urandom_range(0, 4);
      // both stores filled to the brim, once
      if (phase == 1) run_job(MAX_LEN, MAX_LEN, 0);
      // overflow of either store
      if (phase == 3) begin
        run_job(MAX_LEN + 1 + $urandom_range(0, 2), $urandom_range(0, 4), 0);
        run_job($urandom_range(0, 4), MAX_LEN + 1 + $urandom_range(0, 2), 0);
      end
      repeat ($urandom_range(3, 10)) run_job(pick_len(), pick_len(), noise_pct);
    end

    settle();
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wded_pkg.sv
rtl/wded_cell_unit.sv
rtl/wded_engine.sv
rtl/weighted_dna_edit_distance_top.sv
test/wded_checker.sv
test/tb_top.sv
